### hw/rtl/tcss_pkg.sv
`default_nettype none
// ============================================================================
// tcss_pkg
// Shared constants, types and helpers for the text command stepper sequencer.
// ============================================================================
package tcss_pkg;

    localparam int LINE_MAX = 20;
    localparam int LEN_W    = $clog2(LINE_MAX + 1);
    localparam int IDX_W    = $clog2(LINE_MAX);
    localparam int PADDR_W  = 3;

    localparam logic [6:0] MAX_STEPS_RST   = 7'd100;
    localparam logic [7:0] STEP_PERIOD_RST = 8'd2;
    localparam logic [9:0] COUNT_SAT       = 10'd1000;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_S     = 8'h53;

    localparam logic [1:0] EV_NONE   = 2'd0;
    localparam logic [1:0] EV_START  = 2'd1;
    localparam logic [1:0] EV_STOP   = 2'd2;
    localparam logic [1:0] EV_IGNORE = 2'd3;

    // Register index, taken from address bit 2.
    localparam logic REG_MAX_STEPS   = 1'b0;
    localparam logic REG_STEP_PERIOD = 1'b1;

    typedef struct packed {
        logic item_op;
        logic scan_start;
        logic scan_run;
        logic line_done;
    } tcss_cmd_t;

    typedef struct packed {
        logic newline;
        logic len_zero;
        logic scan_done;
    } tcss_status_t;

    typedef struct packed {
        logic       valid;
        logic       stop;
        logic       right;
        logic [6:0] count;
    } tcss_held_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
               (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic logic [3:0] half_step_pattern(input logic [2:0] pos);
        logic [3:0] pat;
        case (pos)
            3'd0:    pat = 4'd1;
            3'd1:    pat = 4'd3;
            3'd2:    pat = 4'd2;
            3'd3:    pat = 4'd6;
            3'd4:    pat = 4'd4;
            3'd5:    pat = 4'd12;
            3'd6:    pat = 4'd8;
            default: pat = 4'd9;
        endcase
        return pat;
    endfunction

endpackage
`default_nettype wire

### hw/rtl/tcss_ctrl.sv
`default_nettype none
// ============================================================================
// tcss_ctrl
// Controller: accepts items, sequences the line scan and owns output valid.
// ============================================================================
module tcss_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire logic                  kind,
    input  wire tcss_pkg::tcss_status_t status,
    output tcss_pkg::tcss_cmd_t        cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;
    logic   start_line;

    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept     = in_valid && in_ready;
    assign start_line = !kind && status.newline && !status.len_zero;
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (start_line)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.item_op = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.scan_done)
                begin
                    cmd.line_done = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    cmd.scan_run = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.item_op || cmd.line_done)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/tcss_datapath.sv
`default_nettype none
// ============================================================================
// tcss_datapath
// Line buffer, character parser, motion state and result registers.
// ============================================================================
module tcss_datapath (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tcss_pkg::tcss_cmd_t    cmd,
    output tcss_pkg::tcss_status_t      status,
    input  wire logic                   kind,
    input  wire logic [7:0]             rx_byte,
    input  wire logic [6:0]             max_steps,
    input  wire logic [7:0]             step_period,
    output logic [3:0]                  coil_pattern,
    output logic                        moving,
    output logic [1:0]                  event_res,
    output logic [2:0]                  phase
);

    typedef enum logic [2:0] {
        PS_LEAD,
        PS_FIRST,
        PS_TAIL,
        PS_SKIP,
        PS_DIG,
        PS_DONE,
        PS_BAD
    } parse_t;

    logic [7:0] line_mem [tcss_pkg::LINE_MAX];
    logic [7:0] rdata_reg;

    logic [tcss_pkg::LEN_W-1:0] len_reg, len_next;
    logic [tcss_pkg::LEN_W-1:0] rd_idx_reg, rd_idx_next;
    logic                       rd_pend_reg, rd_pend_next;
    logic                       mem_we, mem_re;

    parse_t     ps_reg, ps_next;
    logic [7:0] c0_reg, c0_next;
    logic       neg_reg, neg_next;
    logic [9:0] val_reg, val_next;

    logic [2:0]           seq_reg, seq_next;
    logic [6:0]           steps_reg, steps_next;
    logic                 right_reg, right_next;
    logic [7:0]           tick_reg, tick_next;
    logic [3:0]           coil_reg, coil_next;
    tcss_pkg::tcss_held_t held_reg, held_next;
    logic [1:0]           ev_next;

    logic [3:0] coil_out_reg;
    logic [1:0] ev_out_reg;
    logic [2:0] seq_out_reg;

    logic                 is_digit;
    logic [13:0]          acc;
    logic [7:0]           tick_inc;
    logic                 run_go;
    tcss_pkg::tcss_held_t run_c;
    tcss_pkg::tcss_held_t dec;
    logic                 full;

    assign full             = (len_reg >= tcss_pkg::LEN_W'(tcss_pkg::LINE_MAX));
    assign status.newline   = (rx_byte == tcss_pkg::CH_LF);
    assign status.len_zero  = (len_reg == '0);
    assign status.scan_done = (rd_idx_reg == len_reg) && !rd_pend_reg;

    assign mem_we = cmd.item_op && !kind && !status.newline && !full;
    assign mem_re = cmd.scan_run && (rd_idx_reg < len_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[len_reg[tcss_pkg::IDX_W-1:0]] <= rx_byte;
        end
        if (mem_re)
        begin
            rdata_reg <= line_mem[rd_idx_reg[tcss_pkg::IDX_W-1:0]];
        end
    end

    // Character parser, one stored character per cycle.
    assign is_digit = (rdata_reg >= tcss_pkg::CH_ZERO) && (rdata_reg <= tcss_pkg::CH_NINE);
    assign acc      = ({4'b0, val_reg} << 3) + ({4'b0, val_reg} << 1) + {10'b0, rdata_reg[3:0]};

    always_comb
    begin
        rd_idx_next  = rd_idx_reg;
        rd_pend_next = rd_pend_reg;
        ps_next      = ps_reg;
        c0_next      = c0_reg;
        neg_next     = neg_reg;
        val_next     = val_reg;
        if (cmd.scan_start)
        begin
            rd_idx_next  = '0;
            rd_pend_next = 1'b0;
            ps_next      = PS_LEAD;
            neg_next     = 1'b0;
            val_next     = '0;
        end
        else if (cmd.scan_run)
        begin
            rd_pend_next = mem_re;
            if (mem_re)
            begin
                rd_idx_next = rd_idx_reg + tcss_pkg::LEN_W'(1);
            end
            if (rd_pend_reg)
            begin
                unique case (ps_reg)
                    PS_LEAD:
                    begin
                        if (!tcss_pkg::is_ws(rdata_reg))
                        begin
                            c0_next = rdata_reg;
                            ps_next = PS_FIRST;
                        end
                    end
                    PS_FIRST:
                    begin
                        if (rdata_reg == tcss_pkg::CH_COLON)
                        begin
                            ps_next = ((c0_reg == tcss_pkg::CH_R) || (c0_reg == tcss_pkg::CH_L))
                                      ? PS_SKIP : PS_BAD;
                        end
                        else if (tcss_pkg::is_ws(rdata_reg))
                        begin
                            ps_next = PS_TAIL;
                        end
                        else
                        begin
                            ps_next = PS_BAD;
                        end
                    end
                    PS_TAIL:
                    begin
                        if (!tcss_pkg::is_ws(rdata_reg))
                        begin
                            ps_next = PS_BAD;
                        end
                    end
                    PS_SKIP:
                    begin
                        if (tcss_pkg::is_ws(rdata_reg))
                        begin
                            ps_next = PS_SKIP;
                        end
                        else if ((rdata_reg == tcss_pkg::CH_PLUS) ||
                                 (rdata_reg == tcss_pkg::CH_MINUS))
                        begin
                            neg_next = (rdata_reg == tcss_pkg::CH_MINUS);
                            ps_next  = PS_DIG;
                        end
                        else if (is_digit)
                        begin
                            val_next = (acc > {4'b0, tcss_pkg::COUNT_SAT})
                                       ? tcss_pkg::COUNT_SAT : acc[9:0];
                            ps_next  = PS_DIG;
                        end
                        else
                        begin
                            ps_next = PS_DONE;
                        end
                    end
                    PS_DIG:
                    begin
                        if (is_digit)
                        begin
                            val_next = (acc > {4'b0, tcss_pkg::COUNT_SAT})
                                       ? tcss_pkg::COUNT_SAT : acc[9:0];
                        end
                        else
                        begin
                            ps_next = PS_DONE;
                        end
                    end
                    PS_DONE: ps_next = PS_DONE;
                    PS_BAD:  ps_next = PS_BAD;
                    default: ps_next = PS_BAD;
                endcase
            end
        end
    end

    // Command decoded from the final parser state.
    always_comb
    begin
        dec       = '0;
        dec.right = (c0_reg == tcss_pkg::CH_R);
        dec.count = val_reg[6:0];
        if (((ps_reg == PS_FIRST) || (ps_reg == PS_TAIL)) && (c0_reg == tcss_pkg::CH_S))
        begin
            dec.valid = 1'b1;
            dec.stop  = 1'b1;
        end
        else if (((ps_reg == PS_SKIP) || (ps_reg == PS_DIG) || (ps_reg == PS_DONE)) &&
                 !neg_reg && (val_reg != '0) && (val_reg <= {3'b0, max_steps}))
        begin
            dec.valid = 1'b1;
        end
    end

    // Motion state update for one item.
    assign tick_inc = (tick_reg == 8'hFF) ? tick_reg : tick_reg + 8'd1;

    always_comb
    begin
        len_next   = len_reg;
        seq_next   = seq_reg;
        steps_next = steps_reg;
        right_next = right_reg;
        tick_next  = tick_reg;
        coil_next  = coil_reg;
        held_next  = held_reg;
        ev_next    = tcss_pkg::EV_NONE;
        run_go     = 1'b0;
        run_c      = held_reg;

        if (cmd.item_op)
        begin
            if (!kind)
            begin
                if (!status.newline)
                begin
                    len_next = full ? '0 : len_reg + tcss_pkg::LEN_W'(1);
                end
            end
            else if (coil_reg != '0)
            begin
                if (tick_inc >= step_period)
                begin
                    tick_next = '0;
                    if (steps_reg != '0)
                    begin
                        seq_next   = right_reg ? seq_reg + 3'd1 : seq_reg - 3'd1;
                        coil_next  = tcss_pkg::half_step_pattern(seq_next);
                        steps_next = steps_reg - 7'd1;
                    end
                    else
                    begin
                        coil_next = '0;
                        if (held_reg.valid)
                        begin
                            held_next = '0;
                            run_go    = 1'b1;
                        end
                    end
                end
                else
                begin
                    tick_next = tick_inc;
                end
            end
        end

        if (cmd.line_done)
        begin
            len_next = '0;
            if (!dec.valid)
            begin
                ev_next = tcss_pkg::EV_IGNORE;
            end
            else if (coil_reg != '0)
            begin
                held_next = dec;
            end
            else
            begin
                run_go = 1'b1;
                run_c  = dec;
            end
        end

        if (run_go)
        begin
            if (run_c.stop)
            begin
                coil_next = '0;
                ev_next   = tcss_pkg::EV_STOP;
            end
            else
            begin
                right_next = run_c.right;
                seq_next   = run_c.right ? seq_reg + 3'd1 : seq_reg - 3'd1;
                coil_next  = tcss_pkg::half_step_pattern(seq_next);
                steps_next = run_c.count - 7'd1;
                tick_next  = '0;
                ev_next    = tcss_pkg::EV_START;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= '0;
            rd_idx_reg  <= '0;
            rd_pend_reg <= 1'b0;
            ps_reg      <= PS_LEAD;
            c0_reg      <= '0;
            neg_reg     <= 1'b0;
            val_reg     <= '0;
            seq_reg     <= '0;
            steps_reg   <= '0;
            right_reg   <= 1'b0;
            tick_reg    <= '0;
            coil_reg    <= '0;
            held_reg    <= '0;
        end
        else
        begin
            len_reg     <= len_next;
            rd_idx_reg  <= rd_idx_next;
            rd_pend_reg <= rd_pend_next;
            ps_reg      <= ps_next;
            c0_reg      <= c0_next;
            neg_reg     <= neg_next;
            val_reg     <= val_next;
            seq_reg     <= seq_next;
            steps_reg   <= steps_next;
            right_reg   <= right_next;
            tick_reg    <= tick_next;
            coil_reg    <= coil_next;
            held_reg    <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.item_op || cmd.line_done)
        begin
            coil_out_reg <= coil_next;
            ev_out_reg   <= ev_next;
            seq_out_reg  <= seq_next;
        end
    end

    assign coil_pattern = coil_out_reg;
    assign moving       = (coil_out_reg != '0);
    assign event_res    = ev_out_reg;
    assign phase        = seq_out_reg;

endmodule
`default_nettype wire

### hw/rtl/text_command_stepper_sequencer_unit.sv
`default_nettype none
// ============================================================================
// text_command_stepper_sequencer_unit
// Turns text lines and millisecond ticks into half-step coil drive patterns.
// ============================================================================
// Input beats carry kind (0 received byte, 1 tick) and rx_byte. Every input
// beat yields exactly one output beat with coil_pattern, moving, event_res
// and phase. For ordinary bytes, ticks and a newline on an empty buffer,
// the result is valid the cycle after the input beat is accepted.
// A newline on a non-empty buffer walks the line buffer one character
// a cycle through its registered read port; the result is registered once
// the scan is done, and the buffer holds at most 20 characters.
// One item is in work at a time. in_ready drops during a line scan and
// while an unconsumed result sits in the output register and out_ready is
// low; a stalled receiver therefore holds back the next input beat, and no
// result is lost or repeated.
// The APB port sets max_steps (address 0) and step_period (address 4) and
// should be written only while the block is idle.
// Reset clears the line length, motion state, held command and output
// valid, and restores max_steps to 100 and step_period to 2.
// ============================================================================
module text_command_stepper_sequencer_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tcss_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          kind,
    input  wire logic [7:0]                    rx_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [3:0]                         coil_pattern,
    output logic                               moving,
    output logic [1:0]                         event_res,
    output logic [2:0]                         phase
);

    logic [6:0] max_steps_reg, max_steps_next;
    logic [7:0] step_period_reg, step_period_next;
    logic       cfg_write;

    tcss_pkg::tcss_cmd_t    cmd;
    tcss_pkg::tcss_status_t status;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        max_steps_next   = max_steps_reg;
        step_period_next = step_period_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                tcss_pkg::REG_MAX_STEPS:   max_steps_next   = pwdata[6:0];
                tcss_pkg::REG_STEP_PERIOD: step_period_next = pwdata[7:0];
                default:                   max_steps_next   = max_steps_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            tcss_pkg::REG_MAX_STEPS:   prdata = 32'(max_steps_reg);
            tcss_pkg::REG_STEP_PERIOD: prdata = 32'(step_period_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_steps_reg   <= tcss_pkg::MAX_STEPS_RST;
            step_period_reg <= tcss_pkg::STEP_PERIOD_RST;
        end
        else
        begin
            max_steps_reg   <= max_steps_next;
            step_period_reg <= step_period_next;
        end
    end

    tcss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .status    (status),
        .cmd       (cmd)
    );

    tcss_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .kind         (kind),
        .rx_byte      (rx_byte),
        .max_steps    (max_steps_reg),
        .step_period  (step_period_reg),
        .coil_pattern (coil_pattern),
        .moving       (moving),
        .event_res    (event_res),
        .phase        (phase)
    );

    // A finished line always produces a result beat in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.line_done |=> out_valid)
        else $error("line decode finished without a result beat");

    // No new input beat is taken while a line scan is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan_run || cmd.line_done) |-> !in_ready)
        else $error("input accepted during line scan");

    // An ordinary item and a line scan never start together.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.item_op && cmd.scan_start))
        else $error("conflicting item commands");

    // The moving flag follows the coil drive on every result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (moving == (coil_pattern != 4'd0)))
        else $error("moving flag disagrees with coil drive");

endmodule
`default_nettype wire

### test/text_command_stepper_sequencer_unit_test.sv
// ============================================================================
// text_command_stepper_sequencer_unit_test
// Self-checking bench for the text command stepper sequencer. A behavioral
// model of the line decoder and half-step sequencer predicts every output
// beat. Directed lines, random command streams, register extremes and a long
// output stall are driven through the valid/ready ports and the APB port.
// ============================================================================
module text_command_stepper_sequencer_unit_test;

    import tcss_pkg::*;

    typedef struct packed {
        logic [3:0] coils;
        logic       driving;
        logic [1:0] event_code;
        logic [2:0] position;
    } drive_beat_t;

    localparam logic [3:0] COIL_SEQUENCE [8] = '{4'd1, 4'd3, 4'd2, 4'd6,
                                                 4'd4, 4'd12, 4'd8, 4'd9};
    localparam logic [7:0] BLANK_CHARS [5] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};

    logic                clk = 1'b0;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                in_valid;
    logic                in_ready;
    logic                kind;
    logic [7:0]          rx_byte;
    logic                out_valid;
    logic                out_ready;
    logic [3:0]          coil_pattern;
    logic                moving;
    logic [1:0]          event_res;
    logic [2:0]          phase;

    text_command_stepper_sequencer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .coil_pattern (coil_pattern),
        .moving       (moving),
        .event_res    (event_res),
        .phase        (phase)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Sequencer state as the bench expects it.
    logic [6:0]  cfg_max_steps;
    logic [7:0]  cfg_step_period;
    logic [7:0]  line_buf [LINE_MAX];
    int          line_len;
    logic [2:0]  step_pos;
    logic [6:0]  steps_remaining;
    logic        dir_right;
    logic [7:0]  tick_cnt;
    logic [3:0]  coil_state;
    tcss_held_t  pending_cmd;

    drive_beat_t expected_drive [$];
    drive_beat_t popped;
    logic [7:0]  line_bytes [$];

    int error_count = 0;
    int items_sent = 0;
    int active_items = 0;
    int results_checked = 0;
    int starts_total = 0;
    int stops_total = 0;
    int ignored_total = 0;
    int held_total = 0;
    int overflow_total = 0;
    int settings_total = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int hold_cycles_left = 0;

    task automatic report_mismatch(input string what, input int want, input int got);
        error_count++;
        $display("%0t: mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    endtask

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // Trims the buffered line and turns it into a command; valid stays low
    // when the line is to be ignored.
    function automatic tcss_held_t parse_command_line();
        int          first;
        int          last;
        int          p;
        int unsigned value;
        logic        negative;
        tcss_held_t  cmd;
        first = 0;
        last = line_len;
        value = 0;
        negative = 1'b0;
        cmd = '0;
        while (first < last && is_blank(line_buf[first]))
            first++;
        while (last > first && is_blank(line_buf[last - 1]))
            last--;
        if (last - first == 1 && line_buf[first] == CH_S)
        begin
            cmd.valid = 1'b1;
            cmd.stop = 1'b1;
            return cmd;
        end
        if (last - first < 2)
            return cmd;
        if (line_buf[first + 1] != CH_COLON)
            return cmd;
        if (line_buf[first] != CH_R && line_buf[first] != CH_L)
            return cmd;
        p = first + 2;
        while (p < last && is_blank(line_buf[p]))
            p++;
        if (p < last && (line_buf[p] == CH_PLUS || line_buf[p] == CH_MINUS))
        begin
            negative = line_buf[p] == CH_MINUS;
            p++;
        end
        while (p < last && line_buf[p] >= CH_ZERO && line_buf[p] <= CH_NINE)
        begin
            value = value * 10 + (line_buf[p] - CH_ZERO);
            if (value > COUNT_SAT)
                value = COUNT_SAT;
            p++;
        end
        if (negative || value == 0 || value > cfg_max_steps)
            return cmd;
        cmd.valid = 1'b1;
        cmd.right = line_buf[first] == CH_R;
        cmd.count = value[6:0];
        return cmd;
    endfunction

    function automatic void take_half_step();
        if (dir_right)
            step_pos = step_pos + 3'd1;
        else
            step_pos = step_pos - 3'd1;
        coil_state = COIL_SEQUENCE[step_pos];
    endfunction

    function automatic logic [1:0] start_command(input tcss_held_t cmd);
        if (cmd.stop)
        begin
            coil_state = 4'd0;
            return EV_STOP;
        end
        dir_right = cmd.right;
        take_half_step();
        steps_remaining = cmd.count - 7'd1;
        tick_cnt = 8'd0;
        return EV_START;
    endfunction

    task automatic predict_coil_drive(input logic k, input logic [7:0] b);
        tcss_held_t  cmd;
        logic [1:0]  ev;
        drive_beat_t beat;
        ev = EV_NONE;
        items_sent++;
        // A tick with the coils off changes nothing.
        if (!(k && coil_state == 4'd0))
            active_items++;
        if (!k)
        begin
            if (b == CH_LF)
            begin
                if (line_len > 0)
                begin
                    cmd = parse_command_line();
                    line_len = 0;
                    if (!cmd.valid)
                        ev = EV_IGNORE;
                    else if (coil_state != 4'd0)
                    begin
                        pending_cmd = cmd;
                        held_total++;
                    end
                    else
                        ev = start_command(cmd);
                end
            end
            else if (line_len >= LINE_MAX)
            begin
                line_len = 0;
                overflow_total++;
            end
            else
            begin
                line_buf[line_len] = b;
                line_len++;
            end
        end
        else if (coil_state != 4'd0)
        begin
            if (tick_cnt != 8'hFF)
                tick_cnt++;
            if (tick_cnt >= cfg_step_period)
            begin
                tick_cnt = 8'd0;
                if (steps_remaining != 7'd0)
                begin
                    take_half_step();
                    steps_remaining--;
                end
                else
                begin
                    coil_state = 4'd0;
                    if (pending_cmd.valid)
                    begin
                        cmd = pending_cmd;
                        pending_cmd = '0;
                        ev = start_command(cmd);
                    end
                end
            end
        end
        case (ev)
            EV_START:  starts_total++;
            EV_STOP:   stops_total++;
            EV_IGNORE: ignored_total++;
            default:   ;
        endcase
        beat.coils = coil_state;
        beat.driving = coil_state != 4'd0;
        beat.event_code = ev;
        beat.position = step_pos;
        expected_drive.push_back(beat);
    endtask

    task automatic send_item(input logic k, input logic [7:0] b);
        if ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        kind <= k;
        rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        predict_coil_drive(k, b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b0, s[i]);
    endtask

    task automatic send_ticks(input int n);
        repeat (n)
            send_item(1'b1, 8'($urandom_range(255)));
    endtask

    // Ticks until the coils are off, held commands included.
    task automatic finish_move();
        while (coil_state != 4'd0)
            send_item(1'b1, 8'($urandom_range(255)));
    endtask

    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (expected_drive.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic program_register(input logic index, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {index, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (index == REG_MAX_STEPS)
            cfg_max_steps = value[6:0];
        else
            cfg_step_period = value[7:0];
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (index == REG_MAX_STEPS && prdata[6:0] !== value[6:0])
            report_mismatch("max_steps readback", value[6:0], prdata[6:0]);
        if (index == REG_STEP_PERIOD && prdata[7:0] !== value[7:0])
            report_mismatch("step_period readback", value[7:0], prdata[7:0]);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_registers(input logic [6:0] steps_limit, input logic [7:0] period);
        logic [31:0] noise;
        wait_until_idle();
        // Upper data bits are random; only the register width is kept.
        noise = $urandom();
        program_register(REG_MAX_STEPS, {noise[31:7], steps_limit});
        noise = $urandom();
        program_register(REG_STEP_PERIOD, {noise[31:8], period});
        settings_total++;
    endtask

    function automatic void add_blanks();
        int n;
        n = $urandom_range(1, 2);
        repeat (n)
            line_bytes.push_back(BLANK_CHARS[$urandom_range(4)]);
    endfunction

    function automatic void add_decimal(input int unsigned value);
        logic [7:0] digits [$];
        if ($urandom_range(9) == 0)
            line_bytes.push_back(CH_ZERO);
        do
        begin
            digits.push_front(8'(CH_ZERO + value % 10));
            value = value / 10;
        end
        while (value != 0);
        foreach (digits[i])
            line_bytes.push_back(digits[i]);
    endfunction

    // Mostly counts that will run, with some zero, too large and
    // saturating ones.
    function automatic int unsigned pick_step_count();
        int unsigned top;
        int unsigned r;
        top = cfg_max_steps;
        if (top == 0)
            top = 1;
        r = $urandom_range(99);
        if (r < 65)
            return $urandom_range(1, (top < 8) ? top : 8);
        if (r < 85)
            return $urandom_range(1, top);
        if (r < 90)
            return 0;
        if (r < 95)
            return top + $urandom_range(1, 30);
        return $urandom_range(1000, 99999);
    endfunction

    task automatic send_random_line();
        int         pick;
        int         n;
        logic [7:0] ch;
        line_bytes = {};
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            if ($urandom_range(3) == 0)
                add_blanks();
            line_bytes.push_back($urandom_range(1) ? CH_R : CH_L);
            line_bytes.push_back(CH_COLON);
            if ($urandom_range(4) == 0)
                add_blanks();
            n = $urandom_range(19);
            if (n == 0)
                line_bytes.push_back(CH_PLUS);
            else if (n == 1)
                line_bytes.push_back(CH_MINUS);
            add_decimal(pick_step_count());
            // A trailing letter ends the number early.
            if ($urandom_range(9) == 0)
                line_bytes.push_back(8'($urandom_range(8'h41, 8'h5A)));
            if ($urandom_range(3) == 0)
                add_blanks();
        end
        else if (pick < 62)
        begin
            if ($urandom_range(2) == 0)
                add_blanks();
            line_bytes.push_back(CH_S);
            if ($urandom_range(2) == 0)
                add_blanks();
        end
        else if (pick < 74)
        begin
            n = $urandom_range(1, 10);
            repeat (n)
                line_bytes.push_back(8'($urandom_range(255)));
        end
        else if (pick < 82)
        begin
            // Long enough to fill the buffer and usually to overflow it.
            n = $urandom_range(LINE_MAX, LINE_MAX + 6);
            repeat (n)
            begin
                ch = 8'($urandom_range(255));
                if (ch == CH_LF)
                    ch = 8'hFF;
                line_bytes.push_back(ch);
            end
            if ($urandom_range(1) == 1)
            begin
                line_bytes.push_back(CH_L);
                line_bytes.push_back(CH_COLON);
                line_bytes.push_back(8'(CH_ZERO + 1));
            end
        end
        else if (pick < 94)
        begin
            case ($urandom_range(5))
                0:
                begin
                    line_bytes.push_back(CH_R);
                    line_bytes.push_back(8'(CH_ZERO + 3));
                end
                1:
                begin
                    line_bytes.push_back(CH_L);
                    line_bytes.push_back(CH_COLON);
                end
                2:
                begin
                    line_bytes.push_back(CH_S);
                    line_bytes.push_back(CH_S);
                end
                3:
                begin
                    line_bytes.push_back(CH_S);
                    line_bytes.push_back(CH_COLON);
                    line_bytes.push_back(8'(CH_ZERO + 1));
                end
                4:
                begin
                    line_bytes.push_back(8'h72);
                    line_bytes.push_back(CH_COLON);
                    line_bytes.push_back(8'(CH_ZERO + 5));
                end
                default:
                begin
                    line_bytes.push_back(CH_R);
                    line_bytes.push_back(CH_COLON);
                    line_bytes.push_back(CH_PLUS);
                    line_bytes.push_back(CH_MINUS);
                    line_bytes.push_back(8'(CH_ZERO + 3));
                end
            endcase
        end
        else if (pick >= 97)
            add_blanks();
        line_bytes.push_back(CH_LF);
        foreach (line_bytes[i])
            send_item(1'b0, line_bytes[i]);
    endtask

    task automatic drive_random_traffic(input int beats, input logic with_holds);
        int start;
        int pick;
        int actions;
        start = active_items;
        actions = 0;
        while (active_items - start < beats)
        begin
            if (with_holds && actions % 60 == 0)
                hold_cycles_left = $urandom_range(100, 250);
            actions++;
            pick = $urandom_range(99);
            if (pick < 60)
                send_random_line();
            else if (pick < 88)
                send_ticks($urandom_range(1, 4));
            else
                finish_move();
        end
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        sender_idle_pct = sender_pct;
        receiver_idle_pct = receiver_pct;
    endtask

    task automatic test_directed_cases();
        send_item(1'b1, 8'h00);
        send_item(1'b0, CH_LF);
        send_text("S\n");
        send_item(1'b0, 8'h00);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, CH_LF);
        send_text("R:2\n");
        // Decoded during the move, so it waits and runs when the move ends.
        send_text("S\n");
        finish_move();
        send_text(" L:1\t\n");
        finish_move();
        send_item(1'b1, 8'hFF);
    endtask

    task automatic test_command_mix(input logic [6:0] steps_limit, input logic [7:0] period,
                                    input int beats);
        set_registers(steps_limit, period);
        drive_random_traffic(beats, 1'b0);
    endtask

    task automatic test_register_extremes();
        finish_move();
        set_registers(7'd1, 8'd255);
        drive_random_traffic(400, 1'b0);
        set_registers(7'd0, 8'd0);
        drive_random_traffic(80, 1'b0);
        set_registers(7'd127, 8'd0);
        drive_random_traffic(250, 1'b0);
    endtask

    task automatic test_output_stall();
        set_registers(MAX_STEPS_RST, STEP_PERIOD_RST);
        drive_random_traffic(350, 1'b1);
    endtask

    // Receiver: random ready, or a long hold-off when one is requested.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles_left > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles_left--;
            end
            else
                out_ready <= $urandom_range(99) >= receiver_idle_pct;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (expected_drive.size() == 0)
                report_mismatch("beat with nothing expected, event_res", -1, event_res);
            else
            begin
                popped = expected_drive.pop_front();
                if (coil_pattern !== popped.coils)
                    report_mismatch("coil_pattern", popped.coils, coil_pattern);
                if (moving !== popped.driving)
                    report_mismatch("moving", popped.driving, moving);
                if (event_res !== popped.event_code)
                    report_mismatch("event_res", popped.event_code, event_res);
                if (phase !== popped.position)
                    report_mismatch("phase", popped.position, phase);
            end
        end
    end

    initial
    begin
        #5000000;
        $display("%0t: timeout with %0d beats outstanding", $time, expected_drive.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        kind = 1'b0;
        rx_byte = 8'h00;
        cfg_max_steps = MAX_STEPS_RST;
        cfg_step_period = STEP_PERIOD_RST;
        line_len = 0;
        step_pos = 3'd0;
        steps_remaining = 7'd0;
        dir_right = 1'b0;
        tick_cnt = 8'd0;
        coil_state = 4'd0;
        pending_cmd = '0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(30, 61);
        test_directed_cases();
        test_command_mix(7'd127, 8'd1, 450);
        set_idling(61, 30);
        test_register_extremes();
        set_idling(0, 0);
        test_command_mix(7'd6, 8'd3, 400);
        test_output_stall();

        wait_until_idle();
        repeat (30)
            @(posedge clk);
        if (expected_drive.size() != 0)
            report_mismatch("beats never delivered", 0, expected_drive.size());

        $display("Sent %0d beats (%0d doing work) and checked %0d result beats.",
                 items_sent, active_items, results_checked);
        $display("Moves %0d, stops %0d, ignored lines %0d, held %0d, overflows %0d, settings %0d.",
                 starts_total, stops_total, ignored_total, held_total, overflow_total,
                 settings_total);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
